// ===== hw/rtl/lru_frame_replacer_top_defines.svh =====
// Assertion helpers for the replacer top module.
`ifndef LRU_FRAME_REPLACER_TOP_DEFINES_SVH
`define LRU_FRAME_REPLACER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LFR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lfr_pkg.sv =====
package lfr_pkg;

  localparam int unsigned FRAME_W = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned MODE_W  = 2;

  // Distinct frame numbers bound the number of evictable entries.
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(1 << FRAME_W);

  localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PIN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNPIN  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

  // One list entry held in a cell.
  typedef struct packed {
    logic               v;
    logic [FRAME_W-1:0] fr;
    logic               ev;
  } ent_t;

  // Request token walking down the chain, one cell per cycle.
  typedef struct packed {
    logic               act;
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] frame;
    logic               shift;   // compaction in progress
    logic               done;
    logic               found;
    logic [FRAME_W-1:0] vframe;
    logic               dec;     // an evictable entry was pinned
    logic               inc;     // an entry became evictable
  } tok_t;

endpackage

// ===== hw/rtl/lru_frame_replacer_top.sv =====
// LRU frame replacer.
// Input stream: s_axis_tuser carries the request kind (victim, pin, unpin,
// count query), s_axis_tdata the frame number. Output stream: one word per
// request; m_axis_tuser flags a found victim, m_axis_tdata carries the
// victim frame and the evictable count after the request.
// The list lives in a row of FRAMES cells, oldest entry in cell 0. A request
// enters as a token and moves one cell per cycle; cells match, mark, append
// and compact by pulling their right neighbor's entry as the token passes.
// A request's token passes the FRAMES cell registers; its word then goes to
// the pending and then the output register. No new request is taken before
// the word leaves the pending register; tready is low while one is in flight.
// A finished word sits in a pending register until the output register is
// free, so a stalled receiver holds the block busy without losing data.
// Reset empties the list and clears the evictable count; no sweep is needed.
`include "lru_frame_replacer_top_defines.svh"

module lru_frame_replacer_top import lfr_pkg::*; #(
  parameter int unsigned FRAMES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] frame_number, [7:6] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] victim_frame, [12:6] evictable_count
  output logic [0:0]  m_axis_tuser    // [0] victim_found
);

  tok_t tok [FRAMES+1];
  ent_t ent [FRAMES];

  logic s_fire;
  logic busy_q;
  logic pend_q;
  logic pend_found_q;
  logic [FRAME_W-1:0] pend_frame_q;
  logic [COUNT_W-1:0] tot_q, tot_d;
  logic out_valid_q;
  logic out_found_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [COUNT_W-1:0] out_count_q;
  logic out_free;
  tok_t exit_tok;

  assign s_axis_tready = !busy_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    tok[0]       = '0;
    tok[0].act   = s_fire;
    tok[0].mode  = s_axis_tuser;
    tok[0].frame = s_axis_tdata[FRAME_W-1:0];
  end

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    ent_t nxt;
    if (i == FRAMES - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    lfr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .nxt_i  (nxt),
      .ent_o  (ent[i]),
      .tok_o  (tok[i+1])
    );
  end

  assign exit_tok = tok[FRAMES];
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    tot_d = tot_q;
    if (exit_tok.act) begin
      tot_d = tot_q - COUNT_W'(exit_tok.dec) - COUNT_W'(exit_tok.found)
              + COUNT_W'(exit_tok.inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      tot_q       <= '0;
    end else begin
      tot_q <= tot_d;
      if (s_fire) busy_q <= 1'b1;
      if (exit_tok.act) begin
        pend_q <= 1'b1;
      end else if (pend_q && out_free) begin
        pend_q <= 1'b0;
        busy_q <= 1'b0;
      end
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_tok.act) begin
      pend_found_q <= exit_tok.found;
      pend_frame_q <= exit_tok.found ? exit_tok.vframe : '0;
    end
    if (pend_q && out_free) begin
      out_found_q <= pend_found_q;
      out_frame_q <= pend_frame_q;
      out_count_q <= tot_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_frame_q};

  `LFR_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, s_fire, busy_q, "accept did not set busy")
  `LFR_ASSERT_NOW(a_exit_busy, clk_i, rst_ni, exit_tok.act, busy_q && !pend_q, "stray token exit")
  `LFR_ASSERT_NOW(a_pend_busy, clk_i, rst_ni, pend_q, busy_q && !s_axis_tready, "pending while idle")
  `LFR_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, tot_q <= MAX_COUNT, "evictable count overflow")

endmodule

// ===== hw/rtl/lfr_cell.sv =====
module lfr_cell import lfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  input  ent_t nxt_i,
  output ent_t ent_o,
  output tok_t tok_o
);

  ent_t ent_q, ent_d;
  tok_t tok_q, tok_d;
  logic hit;

  assign hit = ent_q.v && (ent_q.fr == tok_i.frame);

  always_comb begin
    ent_d = ent_q;
    tok_d = tok_i;
    if (tok_i.act && !tok_i.done) begin
      case (tok_i.mode)
        MODE_VICTIM: begin
          if (tok_i.shift) begin
            ent_d = nxt_i;
            if (!nxt_i.v) tok_d.done = 1'b1;
          end else if (!ent_q.v) begin
            tok_d.done = 1'b1;
          end else if (ent_q.ev) begin
            tok_d.found  = 1'b1;
            tok_d.vframe = ent_q.fr;
            tok_d.shift  = 1'b1;
            ent_d        = nxt_i;
            if (!nxt_i.v) tok_d.done = 1'b1;
          end
        end
        MODE_PIN: begin
          if (tok_i.shift || hit) begin
            if (hit) tok_d.dec = ent_q.ev;
            tok_d.shift = 1'b1;
            if (nxt_i.v) begin
              ent_d = nxt_i;
            end else begin
              // tail reached: the pinned frame lands here
              ent_d.v    = 1'b1;
              ent_d.fr   = tok_i.frame;
              ent_d.ev   = 1'b0;
              tok_d.done = 1'b1;
            end
          end else if (!ent_q.v) begin
            ent_d.v    = 1'b1;
            ent_d.fr   = tok_i.frame;
            ent_d.ev   = 1'b0;
            tok_d.done = 1'b1;
          end
        end
        MODE_UNPIN: begin
          if (hit) begin
            if (!ent_q.ev) begin
              ent_d.ev  = 1'b1;
              tok_d.inc = 1'b1;
            end
            tok_d.done = 1'b1;
          end else if (!ent_q.v) begin
            ent_d.v    = 1'b1;
            ent_d.fr   = tok_i.frame;
            ent_d.ev   = 1'b1;
            tok_d.inc  = 1'b1;
            tok_d.done = 1'b1;
          end
        end
        MODE_QUERY: tok_d.done = 1'b1;
        default:    tok_d.done = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      tok_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_d;
    end
  end

  assign ent_o = ent_q;
  assign tok_o = tok_q;

endmodule
